[hw/rtl/mat_pkg.sv]
// Shared types and constants of the machine assignment table.
package mat_pkg;

	localparam logic [2:0] CMD_FIND_FREE = 3'd0;
	localparam logic [2:0] CMD_FIND_INTR = 3'd1;
	localparam logic [2:0] CMD_ASSIGN    = 3'd2;
	localparam logic [2:0] CMD_PREEMPT   = 3'd3;
	localparam logic [2:0] CMD_MAKESPAN  = 3'd4;

	localparam int CFG_BITS = 5;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  machine_index;
		logic [31:0] query_time;
		logic [31:0] duration;
		logic [31:0] slot_begin;
		logic [31:0] slot_end;
	} mat_request_t;

	typedef struct packed {
		logic        found;
		logic [3:0]  chosen_machine;
		logic [31:0] amount;
		logic        error;
	} mat_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_LAST,
		ST_READ,
		ST_EXEC,
		ST_RESP
	} mat_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_issue;
		logic pre_read;
		logic exec;
	} mat_ctrl_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic is_scan;
		logic is_preempt;
		logic cnt_zero;
		logic scan_last;
	} mat_status_t;

endpackage

[hw/rtl/mat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mat_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[hw/rtl/mat_ctrl.sv]
// Controller state machine of the machine assignment table.
module mat_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mat_pkg::mat_status_t status,
	output mat_pkg::mat_ctrl_t   ctrl,
	output logic                busy,
	output logic                done
);
	import mat_pkg::*;

	mat_state_t state_q;
	mat_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (status.is_scan && !status.cnt_zero) state_d = ST_SCAN;
				else if (status.is_preempt) state_d = ST_READ;
				else state_d = ST_EXEC;
			end
			ST_SCAN: begin
				if (status.scan_last) state_d = ST_LAST;
			end
			ST_LAST:  state_d = ST_RESP;
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_RESP;
			ST_RESP:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				ctrl.load = start;
			end
			ST_SCAN:  ctrl.scan_issue = 1'b1;
			ST_READ:  ctrl.pre_read = 1'b1;
			ST_EXEC:  ctrl.exec = 1'b1;
			ST_RESP:  done = 1'b1;
			default: begin
				ctrl = '0;
			end
		endcase
	end
endmodule

[hw/rtl/mat_dp.sv]
// Datapath: request registers, machine table, scan accumulators and result.
module mat_dp #(
	parameter int MAX_MACHINES = 16,
	parameter int TIME_BITS    = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mat_pkg::mat_request_t                 request,
	input  mat_pkg::mat_ctrl_t                    ctrl,
	input  logic                                  cfg_we,
	input  logic [mat_pkg::CFG_BITS-1:0]          cfg_data,
	output mat_pkg::mat_status_t                  status,
	output mat_pkg::mat_result_t                  result
);
	import mat_pkg::*;

	localparam int IDX_W  = MAX_MACHINES > 1 ? $clog2(MAX_MACHINES) : 1;
	localparam int CNT_RAW = $clog2(MAX_MACHINES + 1);
	localparam int CNT_W  = CNT_RAW > CFG_BITS ? CNT_RAW : CFG_BITS;
	localparam int TB     = TIME_BITS;

	function automatic logic [TB-1:0] to_time(input logic [31:0] v);
		logic [TB+31:0] w;
		w = {{TB{1'b0}}, v};
		return w[TB-1:0];
	endfunction

	function automatic logic [31:0] to_out(input logic [TB-1:0] v);
		logic [TB+31:0] w;
		w = {32'd0, v};
		return w[31:0];
	endfunction

	// Request registers.
	logic [2:0]    cmd_q;
	logic [3:0]    idx_q;
	logic [TB-1:0] t_q;
	logic [TB-1:0] b_q;
	logic [TB-1:0] e_q;

	logic [CFG_BITS-1:0] miu_q;
	logic [MAX_MACHINES-1:0] valid_q;

	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] idx_s1;
	logic             eval_s1;

	logic          found_q;
	logic [3:0]    chosen_q;
	logic [TB-1:0] best_q;
	logic          error_q;

	logic [CNT_W-1:0] n_eff;
	logic [IDX_W+3:0] idx_wide;
	logic [IDX_W-1:0] idx_ram;
	logic [IDX_W+3:0] chosen_wide;
	logic             idx_ok;

	logic [2*TB-1:0] rd_data;
	logic [TB-1:0]   ent_start;
	logic [TB-1:0]   ent_finish;
	logic            ent_valid;
	logic [TB-1:0]   rem;

	logic            ram_we;
	logic [2*TB-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic            assign_ok;
	logic            pre_hit;
	logic            pre_cut;

	assign n_eff = (CNT_W'(miu_q) > CNT_W'(MAX_MACHINES)) ? CNT_W'(MAX_MACHINES)
		: CNT_W'(miu_q);
	assign idx_wide    = {{IDX_W{1'b0}}, idx_q};
	assign idx_ram     = idx_wide[IDX_W-1:0];
	assign chosen_wide = {4'd0, idx_s1};
	assign idx_ok      = CNT_W'(idx_q) < n_eff;

	assign ent_start  = rd_data[2*TB-1:TB];
	assign ent_finish = rd_data[TB-1:0];
	assign ent_valid  = valid_q[idx_s1];
	assign rem        = ent_finish - t_q;

	assign assign_ok = idx_ok && (b_q < e_q);
	assign pre_hit   = idx_ok && valid_q[idx_ram];
	assign pre_cut   = pre_hit && (ent_finish > e_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {b_q, e_q};
		if (ctrl.exec) begin
			case (cmd_q)
				CMD_ASSIGN: ram_we = assign_ok;
				CMD_PREEMPT: begin
					ram_we    = pre_cut;
					ram_wdata = {ent_start, e_q};
				end
				default: ram_we = 1'b0;
			endcase
		end
	end

	assign ram_raddr = ctrl.pre_read ? idx_ram : ptr_q;

	mat_ram #(
		.WIDTH(2 * TB),
		.DEPTH(MAX_MACHINES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_ram),
		.wdata(ram_wdata),
		.re   (ctrl.scan_issue | ctrl.pre_read),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miu_q   <= CFG_RESET;
			valid_q <= '0;
			eval_s1 <= 1'b0;
		end else begin
			if (cfg_we) miu_q <= cfg_data;
			if (ctrl.exec && cmd_q == CMD_ASSIGN && assign_ok) valid_q[idx_ram] <= 1'b1;
			eval_s1 <= ctrl.scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q    <= request.command;
			idx_q    <= request.machine_index;
			t_q      <= to_time(request.query_time);
			b_q      <= to_time(request.slot_begin);
			e_q      <= to_time(request.slot_end);
			ptr_q    <= '0;
			found_q  <= 1'b0;
			chosen_q <= '0;
			error_q  <= 1'b0;
			// The interruptible search starts its running best at the duration,
			// so one compare covers both the duration and the best so far.
			best_q   <= (request.command == CMD_FIND_INTR) ? to_time(request.duration) : '0;
		end
		if (ctrl.scan_issue) begin
			ptr_q  <= ptr_q + IDX_W'(1);
			idx_s1 <= ptr_q;
		end
		if (eval_s1) begin
			case (cmd_q)
				CMD_FIND_FREE: begin
					if (!found_q && (!ent_valid || ent_finish < t_q)) begin
						found_q  <= 1'b1;
						chosen_q <= chosen_wide[3:0];
					end
				end
				CMD_FIND_INTR: begin
					if (ent_valid && !(ent_finish < t_q) && t_q > ent_start && rem > best_q)
					begin
						found_q  <= 1'b1;
						chosen_q <= chosen_wide[3:0];
						best_q   <= rem;
					end
				end
				CMD_MAKESPAN: begin
					if (ent_valid && ent_finish > best_q) best_q <= ent_finish;
				end
				default: begin
					found_q <= found_q;
				end
			endcase
		end
		if (ctrl.exec) begin
			case (cmd_q)
				CMD_ASSIGN: error_q <= !assign_ok;
				CMD_PREEMPT: begin
					found_q <= pre_hit;
					best_q  <= pre_cut ? (ent_finish - e_q) : '0;
				end
				default: begin
					error_q <= 1'b0;
				end
			endcase
		end
	end

	assign status.is_scan    = (cmd_q == CMD_FIND_FREE) || (cmd_q == CMD_FIND_INTR)
		|| (cmd_q == CMD_MAKESPAN);
	assign status.is_preempt = (cmd_q == CMD_PREEMPT);
	assign status.cnt_zero   = (n_eff == '0);
	assign status.scan_last  = (CNT_W'(ptr_q) == n_eff - CNT_W'(1));

	assign result.found          = found_q;
	assign result.chosen_machine = chosen_q;
	assign result.amount         = (cmd_q == CMD_FIND_INTR) ? 32'd0 : to_out(best_q);
	assign result.error          = error_q;
endmodule

[hw/rtl/machine_assignment_table_core.sv]
// Top level of the machine assignment table: controller, datapath and table RAM.
//
// Channel   Direction  Handshake            Contents
// request   in         start, busy          command, index, times
// result    out        done (one cycle)     found, chosen machine, amount, error
// config    in         cfg_valid, cfg_ready machines in use (5 bits)
//
// Search and makespan requests pass through dispatch, one scan step per machine in use,
// a last step and the response; the table RAM is read one entry per cycle on its single
// read port. Preempt passes through dispatch, read, exec and response, assign and unused
// codes through dispatch, exec and response, and busy falls in the cycle after done. Reset
// clears every machine to empty and the count to 16; a machine's times are only used after
// it is assigned. Results cannot be held off: each is valid in the single cycle done is high.
module machine_assignment_table_core #(
	parameter int MAX_MACHINES = 16,
	parameter int TIME_BITS    = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  mat_pkg::mat_request_t         request,
	output logic                          done,
	output mat_pkg::mat_result_t          result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mat_pkg::CFG_BITS-1:0]  cfg_data
);
	import mat_pkg::*;

	mat_ctrl_t   ctrl;
	mat_status_t status;

	assign cfg_ready = !busy;

	mat_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.ctrl  (ctrl),
		.busy  (busy),
		.done  (done)
	);

	mat_dp #(
		.MAX_MACHINES(MAX_MACHINES),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctrl    (ctrl),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.status  (status),
		.result  (result)
	);

	// An accepted request keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// Busy only drops right after a result has been delivered.
	a_busy_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

	// One result per request: no two strobes back to back.
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// A failed assignment reports nothing else.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.error |-> !result.found && result.amount == 32'd0)
		else $error("error result carries other fields");
endmodule
